FILE: sv/brq_pkg.sv
// Shared types and constants for the broadcast ring queue.
// Request kinds, status codes, configuration indexes and fixed field widths.
// No dependencies.
package brq_pkg;

    // Fixed field widths.
    localparam int SEQ_W      = 64;   // sequence numbers, tags, published positions
    localparam int IN_WORD_W  = 64;   // payload word as it travels on the ports
    localparam int NWORDS     = 7;    // payload words per message
    localparam int RID_W      = 3;    // reader id field
    localparam int REQ_W      = 2;    // request kind field
    localparam int STAT_W     = 2;    // status field

    // Configuration port.
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 7;
    localparam int CFG_SLOTS_W   = 7;
    localparam int CFG_READERS_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READERS = 1'd1;

    localparam logic [CFG_SLOTS_W-1:0]   SLOTS_RESET   = 7'd64;
    localparam logic [CFG_READERS_W-1:0] READERS_RESET = 4'd8;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_SEND_FULL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEND_TAG  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RECV      = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE      = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_DONE       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL       = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_READER = 2'd3;

    // Starting value of the reader minimum and the bit that gates republishing.
    localparam logic [SEQ_W-1:0] MIN_START   = 64'h0000_0000_FFFF_FFFF;
    localparam int               PUBLISH_BIT = 5;

endpackage

FILE: sv/brq_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is issued. No dependencies.
module brq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/brq_min_scan.sv
// Sequential minimum over the published reader positions, one reader a cycle.
// Depends on brq_pkg for the sequence width and the starting value.
module brq_min_scan #(
    parameter int MAX_READERS = 8
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            start,
    input  logic [$clog2(MAX_READERS+1)-1:0]                nr,
    input  logic [MAX_READERS-1:0][brq_pkg::SEQ_W-1:0]      pub,
    output logic                                            done,
    output logic [brq_pkg::SEQ_W-1:0]                       lowest
);
    import brq_pkg::*;

    localparam int RIDX_W = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int RCNT_W = $clog2(MAX_READERS + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RIDX_W-1:0] idx_reg, idx_next;
    logic [SEQ_W-1:0]  lowest_reg, lowest_next;
    logic              last;

    // The scan stops after reader nr-1; nr is at least one.
    assign last = (RCNT_W'(idx_reg) + RCNT_W'(1)) >= nr;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        lowest_next = lowest_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            idx_next    = '0;
            lowest_next = MIN_START;
        end
        else if (busy_reg)
        begin
            if (pub[idx_reg] < lowest_reg)
            begin
                lowest_next = pub[idx_reg];
            end
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + RIDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lowest_reg <= lowest_next;
    end

    assign done   = done_reg;
    assign lowest = lowest_reg;

endmodule

FILE: sv/broadcast_ring_queue.sv
// Broadcast ring queue: one writer, up to MAX_READERS readers, tagged slots in RAM.
// A request is latched when accepted and its result registered once the output is free;
// a send at a sync point first scans the readers. One request is handled at a time.
// Reset: asynchronous, active low. After reset a clearing pass zeroes every slot tag
// while s_tready stays low; configuration writes are taken throughout.
// Depends on brq_pkg, brq_ram and brq_min_scan.
module broadcast_ring_queue #(
    parameter int SLOTS       = 64,
    parameter int MAX_READERS = 8,
    parameter int WORD_BITS   = 64
) (
    input  logic                                         clk,
    input  logic                                         rst_n,

    // Configuration write port.
    input  logic                                         cfg_we,
    input  logic [brq_pkg::CFG_IDX_W-1:0]                cfg_index,
    input  logic [brq_pkg::CFG_DATA_W-1:0]               cfg_data,

    // Request channel.
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // s_tdata: reader_id [2:0], word_1 .. word_7 (64 bits each) from bit 3 up,
    // zero padding [455:451].
    input  logic [455:0]                                 s_tdata,
    // s_tuser: req_type [1:0].
    input  logic [brq_pkg::REQ_W-1:0]                    s_tuser,

    // Result channel.
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // m_tdata: out_word_1 .. out_word_7, 64 bits each, out_word_1 in [63:0].
    output logic [brq_pkg::NWORDS*brq_pkg::IN_WORD_W-1:0] m_tdata,
    // m_tuser: status [1:0].
    output logic [brq_pkg::STAT_W-1:0]                   m_tuser
);
    import brq_pkg::*;

    // Slot and reader index and count widths, and payload widths.
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int RIDX_W = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int RCNT_W = $clog2(MAX_READERS + 1);
    localparam int PAY_W  = NWORDS * WORD_BITS;
    localparam int OUT_W  = NWORDS * IN_WORD_W;

    // The writer's first sync point comes from the slot count in force at reset.
    localparam int SYNC_INIT = ((SLOTS < int'(SLOTS_RESET)) ? SLOTS : int'(SLOTS_RESET)) - 1;

    // Controller states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_RECV  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_SYNC  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [SLOT_W-1:0]       clr_addr_reg, clr_addr_next;

    logic [CFG_SLOTS_W-1:0]   cfg_slots_reg;
    logic [CFG_READERS_W-1:0] cfg_readers_reg;

    // Latched request.
    logic [REQ_W-1:0]        req_type_reg, req_type_next;
    logic [RID_W-1:0]        req_id_reg, req_id_next;
    logic [PAY_W-1:0]        req_words_reg, req_words_next;
    logic [SLOT_W-1:0]       rpos_reg, rpos_next;

    // Writer state.
    logic [SLOT_W-1:0]       wslot_reg, wslot_next;
    logic [SEQ_W-1:0]        wseq_reg, wseq_next;
    logic [SEQ_W-1:0]        sync_reg, sync_next;

    // Reader state.
    logic [SLOT_W-1:0]                  rslot_reg [MAX_READERS];
    logic [SLOT_W-1:0]                  rslot_next [MAX_READERS];
    logic [SEQ_W-1:0]                   rseq_reg [MAX_READERS];
    logic [SEQ_W-1:0]                   rseq_next [MAX_READERS];
    logic [MAX_READERS-1:0][SEQ_W-1:0]  rpub_reg, rpub_next;

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic [OUT_W-1:0]        out_words_reg, out_words_next;

    // Effective counts and derived values.
    logic [CNT_W-1:0]        n_slots;
    logic [RCNT_W-1:0]       n_readers;
    logic [SLOT_W-1:0]       wpos;
    logic                    out_free;
    logic                    accept;
    logic [RIDX_W-1:0]       in_ridx;
    logic [RIDX_W-1:0]       ridx;
    logic                    bad_reader;
    logic [SEQ_W-1:0]        rseq_inc;
    logic [SEQ_W-1:0]        sync_cand;
    logic                    do_write;

    // Memory ports.
    logic                    tag_we;
    logic [SLOT_W-1:0]       tag_waddr;
    logic [SEQ_W-1:0]        tag_wdata;
    logic                    pay_we;
    logic                    mem_re;
    logic [SEQ_W-1:0]        tag_rdata;
    logic [PAY_W-1:0]        pay_rdata;

    // Reader minimum.
    logic                    scan_start;
    logic                    scan_done;
    logic [SEQ_W-1:0]        scan_lowest;

    // Next slot after pos, wrapping at the effective slot count.
    function automatic logic [SLOT_W-1:0] slot_advance(input logic [SLOT_W-1:0] pos,
                                                        input logic [CNT_W-1:0]  n);
        logic [CNT_W-1:0] nx;
        nx = CNT_W'(pos) + CNT_W'(1);
        return (nx >= n) ? '0 : nx[SLOT_W-1:0];
    endfunction

    // A pointer left beyond the ring (the slot count was lowered) restarts at slot 0.
    function automatic logic [SLOT_W-1:0] slot_clamp(input logic [SLOT_W-1:0] pos,
                                                      input logic [CNT_W-1:0]  n);
        return (CNT_W'(pos) < n) ? pos : '0;
    endfunction

    // The slot and reader counts are clamped into the range the hardware holds.
    always_comb
    begin
        if (cfg_slots_reg < CFG_SLOTS_W'(2))
        begin
            n_slots = CNT_W'(2);
        end
        else if (int'(cfg_slots_reg) > SLOTS)
        begin
            n_slots = CNT_W'(SLOTS);
        end
        else
        begin
            n_slots = CNT_W'(cfg_slots_reg);
        end

        if (cfg_readers_reg == '0)
        begin
            n_readers = RCNT_W'(1);
        end
        else if (int'(cfg_readers_reg) > MAX_READERS)
        begin
            n_readers = RCNT_W'(MAX_READERS);
        end
        else
        begin
            n_readers = RCNT_W'(cfg_readers_reg);
        end
    end

    assign wpos       = slot_clamp(wslot_reg, n_slots);
    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_ridx    = RIDX_W'(s_tdata[RID_W-1:0]);
    assign ridx       = RIDX_W'(req_id_reg);
    assign bad_reader = int'(req_id_reg) >= int'(n_readers);
    assign rseq_inc   = rseq_reg[ridx] + SEQ_W'(1);
    assign sync_cand  = scan_lowest + SEQ_W'(n_slots - CNT_W'(1));

    // Main controller: one request at a time; receives read the slot RAMs and sends write them.
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        req_type_next   = req_type_reg;
        req_id_next     = req_id_reg;
        req_words_next  = req_words_reg;
        rpos_next       = rpos_reg;
        wslot_next      = wslot_reg;
        wseq_next       = wseq_reg;
        sync_next       = sync_reg;
        rslot_next      = rslot_reg;
        rseq_next       = rseq_reg;
        rpub_next       = rpub_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_words_next  = out_words_reg;
        tag_we          = 1'b0;
        pay_we          = 1'b0;
        mem_re          = 1'b0;
        scan_start      = 1'b0;
        do_write        = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one tag per cycle after reset.
                tag_we        = 1'b1;
                clr_addr_next = clr_addr_reg + SLOT_W'(1);
                if (clr_addr_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    req_type_next = s_tuser;
                    req_id_next   = s_tdata[RID_W-1:0];
                    for (int i = 0; i < NWORDS; i++)
                    begin
                        req_words_next[i*WORD_BITS +: WORD_BITS] =
                            s_tdata[RID_W + i*IN_WORD_W +: WORD_BITS];
                    end
                    if (s_tuser == REQ_RECV)
                    begin
                        // Start the slot read for this reader right away.
                        mem_re = 1'b1;
                        if (int'(s_tdata[RID_W-1:0]) < MAX_READERS)
                        begin
                            rpos_next = slot_clamp(rslot_reg[in_ridx], n_slots);
                        end
                        else
                        begin
                            rpos_next = '0;
                        end
                        state_next = ST_RECV;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                case (req_type_reg) inside
                    REQ_SEND_FULL, REQ_SEND_TAG:
                    begin
                        if (wseq_reg == sync_reg)
                        begin
                            scan_start = 1'b1;
                            state_next = ST_SCAN;
                        end
                        else if (out_free)
                        begin
                            do_write        = 1'b1;
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_DONE;
                            out_words_next  = '0;
                            state_next      = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        // An unknown request only reports done.
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_DONE;
                            out_words_next  = '0;
                            state_next      = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_RECV:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_words_next = '0;
                    state_next     = ST_IDLE;
                    if (bad_reader)
                    begin
                        out_status_next = STAT_BAD_READER;
                    end
                    else if (tag_rdata != rseq_reg[ridx])
                    begin
                        out_status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        out_status_next = STAT_DONE;
                        for (int i = 0; i < NWORDS; i++)
                        begin
                            out_words_next[i*IN_WORD_W +: IN_WORD_W] =
                                IN_WORD_W'(pay_rdata[i*WORD_BITS +: WORD_BITS]);
                        end
                        rslot_next[ridx] = slot_advance(rpos_reg, n_slots);
                        rseq_next[ridx]  = rseq_inc;
                        if (!rseq_inc[PUBLISH_BIT])
                        begin
                            rpub_next[ridx] = rseq_reg[ridx];
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_SYNC;
                end
            end

            ST_SYNC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_words_next = '0;
                    state_next     = ST_IDLE;
                    if (wseq_reg == sync_cand)
                    begin
                        // Slowest reader is a full ring behind: refuse the send.
                        out_status_next = STAT_FULL;
                    end
                    else
                    begin
                        sync_next       = sync_cand;
                        do_write        = 1'b1;
                        out_status_next = STAT_DONE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Commit of a send: stamp the tag, store payload if present, advance.
        if (do_write)
        begin
            tag_we     = 1'b1;
            pay_we     = (req_type_reg == REQ_SEND_FULL);
            wseq_next  = wseq_reg + SEQ_W'(1);
            wslot_next = slot_advance(wpos, n_slots);
        end
    end

    assign tag_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : wpos;
    assign tag_wdata = (state_reg == ST_CLEAR) ? '0 : wseq_reg;

    // Configuration writes are taken in any state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_slots_reg   <= SLOTS_RESET;
            cfg_readers_reg <= READERS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SLOTS)
            begin
                cfg_slots_reg <= cfg_data[CFG_SLOTS_W-1:0];
            end
            else if (cfg_index == REG_READERS)
            begin
                cfg_readers_reg <= cfg_data[CFG_READERS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            wslot_reg     <= '0;
            wseq_reg      <= SEQ_W'(1);
            sync_reg      <= SEQ_W'(SYNC_INIT);
            out_valid_reg <= 1'b0;
            for (int r = 0; r < MAX_READERS; r++)
            begin
                rslot_reg[r] <= '0;
                rseq_reg[r]  <= SEQ_W'(1);
                rpub_reg[r]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            wslot_reg     <= wslot_next;
            wseq_reg      <= wseq_next;
            sync_reg      <= sync_next;
            out_valid_reg <= out_valid_next;
            rslot_reg     <= rslot_next;
            rseq_reg      <= rseq_next;
            rpub_reg      <= rpub_next;
        end
    end

    // Payload-like registers carry no reset.
    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        req_id_reg     <= req_id_next;
        req_words_reg  <= req_words_next;
        rpos_reg       <= rpos_next;
        out_status_reg <= out_status_next;
        out_words_reg  <= out_words_next;
    end

    // Slot tags: cleared after reset, written by sends, read by receives.
    brq_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (mem_re),
        .raddr (rpos_next),
        .rdata (tag_rdata)
    );

    // Slot payloads: written only by full sends, read alongside the tag.
    brq_ram #(
        .WIDTH (PAY_W),
        .DEPTH (SLOTS)
    ) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (wpos),
        .wdata (req_words_reg),
        .re    (mem_re),
        .raddr (rpos_next),
        .rdata (pay_rdata)
    );

    // Minimum of the published reader positions, taken at each sync point.
    brq_min_scan #(
        .MAX_READERS (MAX_READERS)
    ) u_min_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scan_start),
        .nr     (n_readers),
        .pub    (rpub_reg),
        .done   (scan_done),
        .lowest (scan_lowest)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_words_reg;

endmodule
